>>> hw/rtl/itt_pkg.sv
// Shared types, codes and constants of the idle timeout table.
`default_nettype none

package itt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_EXPIRE      = 16;

    localparam int ID_W      = 16;
    localparam int STAMP_W   = 32;
    localparam int TIMEOUT_W = 16;
    localparam int LIMIT_W   = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    typedef logic [2:0]           kind_t;
    typedef logic [ID_W-1:0]      id_t;
    typedef logic [3:0]           event_t;
    typedef logic [STAMP_W-1:0]   stamp_t;
    typedef logic [TIMEOUT_W-1:0] timeout_t;
    typedef logic [LIMIT_W-1:0]   limit_t;

    localparam timeout_t TIMEOUT_RST     = 16'd30;
    localparam limit_t   MAX_ENTRIES_RST = 5'd16;

    localparam kind_t KIND_TICK   = 3'd0;
    localparam kind_t KIND_SWEEP  = 3'd1;
    localparam kind_t KIND_ADD    = 3'd2;
    localparam kind_t KIND_DELETE = 3'd3;
    localparam kind_t KIND_FORBID = 3'd4;

    localparam event_t EV_ADDED      = 4'd0;
    localparam event_t EV_REFRESHED  = 4'd1;
    localparam event_t EV_REJECTED   = 4'd2;
    localparam event_t EV_EXPIRED    = 4'd3;
    localparam event_t EV_DELETED    = 4'd4;
    localparam event_t EV_NOT_FOUND  = 4'd5;
    localparam event_t EV_FORBIDDEN  = 4'd6;
    localparam event_t EV_TICKED     = 4'd7;
    localparam event_t EV_SWEEP_DONE = 4'd8;

    // Register index, taken from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAX     = 1'b1;

    localparam logic ALU_SUB = 1'b0;
    localparam logic ALU_ADD = 1'b1;

    typedef struct packed {
        timeout_t timeout;
        limit_t   max_entries;
    } cfg_t;

    typedef struct packed {
        id_t    id;
        stamp_t deadline;
        stamp_t order;
    } row_t;

    typedef struct packed {
        logic   op;
        stamp_t a;
        stamp_t b;
        stamp_t c;
    } alu_req_t;

    typedef struct packed {
        stamp_t res;
        logic   gt;
    } alu_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/itt_if.sv
// Handshake channels of the idle timeout table: request words in, event words out.
`default_nettype none

interface itt_in_if;
    import itt_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    id_t   conn_id;

    modport source (output valid, output kind, output conn_id, input ready);
    modport sink   (input valid, input kind, input conn_id, output ready);
endinterface

interface itt_out_if;
    import itt_pkg::*;

    logic   valid;
    logic   ready;
    id_t    conn_id_res;
    event_t event_res;
    logic   last;

    modport source (output valid, output conn_id_res, output event_res, output last,
                     input ready);
    modport sink   (input valid, input conn_id_res, input event_res, input last,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/itt_slot_mem.sv
// Slot memory: id, deadline and order stamp per slot, one write and one registered read port.
`default_nettype none

module itt_slot_mem #(
    parameter int DEPTH = itt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire itt_pkg::row_t            wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      itt_pkg::row_t            rd_data
);
    import itt_pkg::*;

    row_t mem [DEPTH];
    row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/itt_alu.sv
// Shared stamp unit: one 32-bit add or subtract followed by an unsigned compare.
`default_nettype none

module itt_alu (
    input  wire itt_pkg::alu_req_t req,
    output      itt_pkg::alu_rsp_t rsp
);
    import itt_pkg::*;

    stamp_t res;

    always_comb
    begin
        if (req.op == ALU_ADD)
        begin
            res = req.a + req.b;
        end
        else
        begin
            res = req.a - req.b;
        end
    end

    assign rsp.res = res;
    assign rsp.gt  = (res > req.c);

endmodule

`default_nettype wire

>>> hw/rtl/itt_seq.sv
// Sequencer of the idle timeout table: slot scans, sweep loop, table updates, result word.
`default_nettype none

module itt_seq #(
    parameter int DEPTH = itt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire itt_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output      logic            in_ready,
    input  wire itt_pkg::kind_t  in_kind,
    input  wire itt_pkg::id_t    in_id,
    output      logic            out_valid,
    input  wire logic            out_ready,
    output      itt_pkg::id_t    out_id,
    output      itt_pkg::event_t out_event,
    output      logic            out_last
);
    import itt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int NW = $clog2(MAX_EXPIRE + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LATE = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_EXEC = 3'd4;

    logic [2:0]       state_reg, state_next;
    kind_t            kind_reg, kind_next;
    id_t              key_reg, key_next;
    logic [DEPTH-1:0] used_reg, used_next;
    logic [DEPTH-1:0] exempt_reg, exempt_next;
    logic [CW-1:0]    count_reg, count_next;
    stamp_t           now_reg, now_next;
    stamp_t           order_reg, order_next;
    logic [IW-1:0]    scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IW-1:0]    rd_idx_reg, rd_idx_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    found_idx_reg, found_idx_next;
    logic             free_reg, free_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic             best_reg, best_next;
    logic [IW-1:0]    best_idx_reg, best_idx_next;
    stamp_t           best_age_reg, best_age_next;
    id_t              best_id_reg, best_id_next;
    stamp_t           best_dl_reg, best_dl_next;
    logic [NW-1:0]    nexp_reg, nexp_next;
    logic             out_valid_reg, out_valid_next;
    id_t              out_id_reg, out_id_next;
    event_t           out_event_reg, out_event_next;
    logic             out_last_reg, out_last_next;

    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    row_t          mem_wr_data;
    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    row_t          mem_rd_data;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;

    logic out_free;
    logic full;
    logic expired;

    itt_slot_mem #(.DEPTH(DEPTH)) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    itt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign full     = LW'(count_reg) >= LW'(cfg.max_entries);
    assign expired  = best_reg && (alu_rsp.res != '0) && !alu_rsp.res[STAMP_W-1];

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        used_next       = used_reg;
        exempt_next     = exempt_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        order_next      = order_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_id_next    = best_id_reg;
        best_dl_next    = best_dl_reg;
        nexp_next       = nexp_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_id_next     = out_id_reg;
        out_event_next  = out_event_reg;
        out_last_next   = out_last_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = found_idx_reg;
        mem_wr_data = '{id: key_reg, deadline: alu_rsp.res, order: order_reg};
        mem_rd_en   = 1'b0;
        mem_rd_addr = scan_idx_reg;
        alu_req     = '{op: ALU_SUB, a: order_reg, b: mem_rd_data.order, c: best_age_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = in_kind;
                    key_next  = in_id;
                    nexp_next = '0;
                    priority if (in_kind == KIND_TICK)
                    begin
                        state_next = ST_EXEC;
                    end
                    else if (in_kind <= KIND_FORBID)
                    begin
                        state_next      = ST_SCAN;
                        scan_idx_next   = '0;
                        issue_done_next = 1'b0;
                        found_next      = 1'b0;
                        free_next       = 1'b0;
                        best_next       = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one slot read per cycle, evaluate it in the next cycle
                if (!issue_done_reg)
                begin
                    mem_rd_en   = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (rd_vld_reg)
                begin
                    if (used_reg[rd_idx_reg] && (mem_rd_data.id == key_reg) && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = rd_idx_reg;
                    end
                    if (!used_reg[rd_idx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (used_reg[rd_idx_reg] && !exempt_reg[rd_idx_reg]
                        && (!best_reg || alu_rsp.gt))
                    begin
                        best_next     = 1'b1;
                        best_idx_next = rd_idx_reg;
                        best_age_next = alu_rsp.res;
                        best_id_next  = mem_rd_data.id;
                        best_dl_next  = mem_rd_data.deadline;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = (kind_reg == KIND_SWEEP) ? ST_LATE : ST_EXEC;
                    end
                end
            end

            ST_LATE:
            begin
                alu_req = '{op: ALU_SUB, a: now_reg, b: best_dl_reg, c: '0};
                if (!expired)
                begin
                    state_next = ST_DONE;
                end
                else if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_id_next            = best_id_reg;
                    out_event_next         = EV_EXPIRED;
                    out_last_next          = 1'b0;
                    used_next[best_idx_reg]   = 1'b0;
                    exempt_next[best_idx_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    nexp_next = nexp_reg + 1'b1;
                    if ((nexp_reg + NW'(1)) == NW'(MAX_EXPIRE))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next      = ST_SCAN;
                        scan_idx_next   = '0;
                        issue_done_next = 1'b0;
                        found_next      = 1'b0;
                        free_next       = 1'b0;
                        best_next       = 1'b0;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = '0;
                    out_event_next = EV_SWEEP_DONE;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_EXEC:
            begin
                alu_req = '{op: ALU_ADD, a: now_reg, b: STAMP_W'(cfg.timeout), c: '0};
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_id_next    = key_reg;
                    out_last_next  = 1'b1;
                    out_event_next = EV_NOT_FOUND;
                    unique case (kind_reg)
                        KIND_TICK:
                        begin
                            now_next       = now_reg + 1'b1;
                            out_id_next    = '0;
                            out_event_next = EV_TICKED;
                        end
                        KIND_ADD:
                        begin
                            priority if (full)
                            begin
                                out_event_next = EV_REJECTED;
                            end
                            else if (found_reg)
                            begin
                                mem_wr_en                  = 1'b1;
                                mem_wr_addr                = found_idx_reg;
                                exempt_next[found_idx_reg] = 1'b0;
                                order_next                 = order_reg + 1'b1;
                                out_event_next             = EV_REFRESHED;
                            end
                            else if (free_reg)
                            begin
                                mem_wr_en                 = 1'b1;
                                mem_wr_addr               = free_idx_reg;
                                used_next[free_idx_reg]   = 1'b1;
                                exempt_next[free_idx_reg] = 1'b0;
                                count_next                = count_reg + 1'b1;
                                order_next                = order_reg + 1'b1;
                                out_event_next            = EV_ADDED;
                            end
                            else
                            begin
                                out_event_next = EV_REJECTED;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (found_reg)
                            begin
                                used_next[found_idx_reg]   = 1'b0;
                                exempt_next[found_idx_reg] = 1'b0;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                                out_event_next = EV_DELETED;
                            end
                        end
                        KIND_FORBID:
                        begin
                            if (found_reg)
                            begin
                                exempt_next[found_idx_reg] = 1'b1;
                                out_event_next             = EV_FORBIDDEN;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            exempt_reg     <= '0;
            count_reg      <= '0;
            now_reg        <= '0;
            order_reg      <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            best_reg       <= 1'b0;
            nexp_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            exempt_reg     <= exempt_next;
            count_reg      <= count_next;
            now_reg        <= now_next;
            order_reg      <= order_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            found_reg      <= found_next;
            free_reg       <= free_next;
            best_reg       <= best_next;
            nexp_reg       <= nexp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        scan_idx_reg  <= scan_idx_next;
        rd_idx_reg    <= rd_idx_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        best_id_reg   <= best_id_next;
        best_dl_reg   <= best_dl_next;
        out_id_reg    <= out_id_next;
        out_event_reg <= out_event_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_event = out_event_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/idle_timeout_table.sv
// Top level of the idle timeout table: configuration registers and request/event channels.
`default_nettype none

// Connection idle-timeout table. Keeps up to TABLE_DEPTH connection ids, each
// with a deadline (now plus timeout_seconds, modulo 2^32), an age stamp and an
// exempt flag. Request words on in_ch: tick (advance the seconds counter),
// sweep (report and drop expired non-exempt entries oldest first, at most 16,
// then a done word), add or refresh, delete and forbid (make exempt). Every
// request except kinds 5 to 7 gives one or more event words on out_ch, the
// final one flagged by last; kinds 5 to 7 are taken and dropped silently.
// Requests are taken one at a time: in_ch.ready is high only while the
// block is idle. Add, delete and forbid walk every slot through the single
// read port of the slot memory, whose read data is registered. A sweep
// walks the table once for each expired entry it removes and once more for
// the final check, since every removal rescans the table for the next
// oldest entry; once 16 entries have gone, the done word follows without a
// further walk. Each event word sits in an output register, so a stalled
// sink only holds the sequencer when the next word is due. Deadline and age
// compares are wrap-safe. Configuration: APB write at byte address 0
// (timeout_seconds, 16 bits, reset 30) and 4 (max_entries, 5 bits, reset
// 16); write only while the block is idle. pready is tied high.
module idle_timeout_table #(
    parameter int TABLE_DEPTH = itt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [itt_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [itt_pkg::PDATA_W-1:0]  pwdata,
    output      logic [itt_pkg::PDATA_W-1:0]  prdata,
    output      logic                         pready,
    itt_in_if.sink                            in_ch,
    itt_out_if.source                         out_ch
);
    import itt_pkg::*;

    timeout_t timeout_reg;
    limit_t   max_entries_reg;
    cfg_t     cfg;
    logic     cfg_wr;

    // Register write on the access phase; paddr[2] selects the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RST;
            max_entries_reg <= MAX_ENTRIES_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_TIMEOUT: timeout_reg     <= pwdata[TIMEOUT_W-1:0];
                REG_MAX:     max_entries_reg <= pwdata[LIMIT_W-1:0];
                default:     timeout_reg     <= timeout_reg;
            endcase
        end
    end

    // Read back: hold the selected register, zero-extended
    always_comb
    begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = PDATA_W'(timeout_reg);
            REG_MAX:     prdata = PDATA_W'(max_entries_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.timeout     = timeout_reg;
    assign cfg.max_entries = max_entries_reg;

    // Sequencer: slot scans, sweep loop and the output word register
    itt_seq #(.DEPTH(TABLE_DEPTH)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_kind   (in_ch.kind),
        .in_id     (in_ch.conn_id),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_id    (out_ch.conn_id_res),
        .out_event (out_ch.event_res),
        .out_last  (out_ch.last)
    );

endmodule

`default_nettype wire

>>> hw/rtl/itt_checker.sv
// Port-level assertions of the idle timeout table and their bind to the top level.
`default_nettype none

module itt_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire itt_pkg::kind_t  in_kind,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire itt_pkg::id_t    out_id,
    input wire itt_pkg::event_t out_event,
    input wire logic            out_last
);
    import itt_pkg::*;

    // A stalled event word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_id)
            && $stable(out_event) && $stable(out_last))
        else $error("event word changed while stalled");

    // A known request occupies the block
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind <= KIND_FORBID) |=> !in_ready)
        else $error("ready stayed high after a request");

    // An unknown kind is dropped at once
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind > KIND_FORBID) |=> in_ready)
        else $error("unknown kind left the block busy");

    // Only expiry words are followed by more words of the same request
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_event != EV_EXPIRED)))
        else $error("last flag does not match event");

    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_event == EV_TICKED) || (out_event == EV_SWEEP_DONE))
            |-> (out_id == '0))
        else $error("tick or done word carries an id");

endmodule

bind idle_timeout_table itt_checker u_itt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_id    (out_ch.conn_id_res),
    .out_event (out_ch.event_res),
    .out_last  (out_ch.last)
);

`default_nettype wire

>>> tb/sv/itt_checker.sv
// Scoreboard of the idle timeout table: mirrors the table, predicts event words and checks them.
`timescale 1ns / 1ps

module itt_scoreboard #(
    parameter int DEPTH = itt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itt_pkg::PADDR_W-1:0] paddr,
    input  logic [itt_pkg::PDATA_W-1:0] pwdata,
    input  logic                        pready,
    itt_in_if                           in_ch,
    itt_out_if                          out_ch,
    output int                          pending_words,
    output int                          fail_count
);
    import itt_pkg::*;

    localparam int NO_ENTRY = -1;

    typedef struct packed {
        id_t    id;
        event_t ev;
        logic   last;
    } event_word_t;

    event_word_t expected_events [$];

    // Mirror of the table
    logic        ent_used     [DEPTH];
    id_t         ent_id       [DEPTH];
    stamp_t      ent_deadline [DEPTH];
    logic        ent_exempt   [DEPTH];
    stamp_t      ent_stamp    [DEPTH];
    stamp_t      age_seq;
    stamp_t      now_sec;
    int unsigned live_count;
    timeout_t    cfg_timeout;
    limit_t      cfg_limit;
    int          errors = 0;

    assign fail_count = errors;

    task automatic clear_table();
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_used[i]     = 1'b0;
            ent_exempt[i]   = 1'b0;
            ent_id[i]       = '0;
            ent_deadline[i] = '0;
            ent_stamp[i]    = '0;
        end
        age_seq     = '0;
        now_sec     = '0;
        live_count  = 0;
        cfg_timeout = TIMEOUT_RST;
        cfg_limit   = MAX_ENTRIES_RST;
        expected_events.delete();
    endtask

    function automatic int lookup_id(id_t id);
        for (int i = 0; i < DEPTH; i++)
            if (ent_used[i] && ent_id[i] == id)
                return i;
        return NO_ENTRY;
    endfunction

    function automatic int free_entry();
        for (int i = 0; i < DEPTH; i++)
            if (!ent_used[i])
                return i;
        return NO_ENTRY;
    endfunction

    // Oldest non-exempt entry: largest distance from the running sequence number
    function automatic int oldest_entry();
        int     best;
        stamp_t best_age;
        stamp_t age;
        best     = NO_ENTRY;
        best_age = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ent_used[i] && !ent_exempt[i])
            begin
                age = age_seq - ent_stamp[i];
                if (best == NO_ENTRY || age > best_age)
                begin
                    best     = i;
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    task automatic restamp(int s);
        ent_deadline[s] = now_sec + stamp_t'(cfg_timeout);
        ent_stamp[s]    = age_seq;
        age_seq         = age_seq + 1;
        ent_exempt[s]   = 1'b0;
    endtask

    task automatic drop_entry(int s);
        ent_used[s]   = 1'b0;
        ent_exempt[s] = 1'b0;
        if (live_count > 0)
            live_count--;
    endtask

    task automatic queue_word(id_t id, event_t ev, logic last);
        event_word_t w;
        w.id   = id;
        w.ev   = ev;
        w.last = last;
        expected_events.push_back(w);
    endtask

    task automatic predict_events(kind_t kind, id_t id);
        int     s;
        int     n;
        stamp_t late;
        unique case (kind)
            KIND_TICK:
            begin
                now_sec = now_sec + 1;
                queue_word('0, EV_TICKED, 1'b1);
            end
            KIND_SWEEP:
            begin
                n = 0;
                while (n < MAX_EXPIRE)
                begin
                    s = oldest_entry();
                    if (s == NO_ENTRY)
                        break;
                    late = now_sec - ent_deadline[s];
                    if (late == '0 || late[STAMP_W-1])
                        break;
                    queue_word(ent_id[s], EV_EXPIRED, 1'b0);
                    drop_entry(s);
                    n++;
                end
                queue_word('0, EV_SWEEP_DONE, 1'b1);
            end
            KIND_ADD:
            begin
                if (live_count >= cfg_limit)
                    queue_word(id, EV_REJECTED, 1'b1);
                else
                begin
                    s = lookup_id(id);
                    if (s != NO_ENTRY)
                    begin
                        restamp(s);
                        queue_word(id, EV_REFRESHED, 1'b1);
                    end
                    else
                    begin
                        s = free_entry();
                        if (s == NO_ENTRY)
                            queue_word(id, EV_REJECTED, 1'b1);
                        else
                        begin
                            ent_used[s] = 1'b1;
                            ent_id[s]   = id;
                            restamp(s);
                            live_count++;
                            queue_word(id, EV_ADDED, 1'b1);
                        end
                    end
                end
            end
            KIND_DELETE:
            begin
                s = lookup_id(id);
                if (s == NO_ENTRY)
                    queue_word(id, EV_NOT_FOUND, 1'b1);
                else
                begin
                    drop_entry(s);
                    queue_word(id, EV_DELETED, 1'b1);
                end
            end
            KIND_FORBID:
            begin
                s = lookup_id(id);
                if (s == NO_ENTRY)
                    queue_word(id, EV_NOT_FOUND, 1'b1);
                else
                begin
                    ent_exempt[s] = 1'b1;
                    queue_word(id, EV_FORBIDDEN, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_word(id_t id, event_t ev, logic last);
        event_word_t want;
        if (expected_events.size() == 0)
        begin
            errors++;
            $error("unexpected event word: conn_id_res %0h event_res %0d last %0b", id, ev, last);
            return;
        end
        want = expected_events[0];
        expected_events.delete(0);
        if (id !== want.id)
        begin
            errors++;
            $error("conn_id_res: expected %0h, actual %0h", want.id, id);
        end
        if (ev !== want.ev)
        begin
            errors++;
            $error("event_res: expected %0d, actual %0d", want.ev, ev);
        end
        if (last !== want.last)
        begin
            errors++;
            $error("last: expected %0b, actual %0b", want.last, last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            pending_words <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                compare_word(out_ch.conn_id_res, out_ch.event_res, out_ch.last);
            if (psel && penable && pwrite && pready)
            begin
                unique case (paddr[2])
                    REG_TIMEOUT: cfg_timeout = pwdata[TIMEOUT_W-1:0];
                    REG_MAX:     cfg_limit   = pwdata[LIMIT_W-1:0];
                    default:     ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_events(in_ch.kind, in_ch.conn_id);
            pending_words <= expected_events.size();
        end
    end

endmodule

>>> tb/sv/tb_idle_timeout_table.sv
// Testbench top of the idle timeout table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_idle_timeout_table;
    import itt_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int CLK_PERIOD    = 10;
    // Quiet margin after the last event word, two table walks long
    localparam int SETTLE_CYCLES = 2 * (DEPTH + 3);
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 250;
    localparam int PHASE_WORDS   = 72;
    localparam int ID_POOL       = 24;
    localparam int NUM_PHASES    = 6;

    // Settings per random phase: both timeout extremes, limits from one up to
    // past the table size so that the table itself runs out of slots
    localparam int PHASE_TIMEOUT [NUM_PHASES] = '{1, 65535, 2, 3, 1, 30};
    localparam int PHASE_LIMIT   [NUM_PHASES] = '{16, 31, 31, 1, 16, 5};

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    itt_in_if  req_ch ();
    itt_out_if evt_ch ();

    int fail_count;
    int pending_words;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cur_timeout   = 30;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    idle_timeout_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (req_ch),
        .out_ch  (evt_ch)
    );

    itt_scoreboard #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_ch         (req_ch),
        .out_ch        (evt_ch),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Event word sink. A hold request freezes ready until the HOLD_CYCLES
    // countdown here ends, so the output register fills and the block stops
    // taking requests while the sender keeps offering. Else drop ready at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            evt_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            evt_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            evt_ch.ready <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
        end
        else
            evt_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: count cycles with no word moving on either channel and no
    // register access; give up once the count reaches the limit
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready)
            || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_idle_timeout_table failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Offer one request word and hold it until the block takes it. Valid stays
    // high into the next word unless a random gap is inserted first.
    task automatic send_word(kind_t kind, id_t conn_id);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.kind    <= kind_t'($urandom());
            req_ch.conn_id <= id_t'($urandom());
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= kind;
        req_ch.conn_id <= conn_id;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drop valid, wait for every predicted word, then idle a while
    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the
    // edge where pready is seen high
    task automatic reg_write(logic reg_sel, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_sel, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Only ever reconfigure an idle block
    task automatic configure(int timeout, int limit);
        settle();
        reg_write(REG_TIMEOUT, PDATA_W'(timeout));
        reg_write(REG_MAX, PDATA_W'(limit));
        cur_timeout = timeout;
    endtask

    initial
    begin
        int  ph;
        int  words;
        int  r;
        int  n;
        id_t pool [ID_POOL];

        rst_n          = 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= KIND_TICK;
        req_ch.conn_id <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings: id extremes, refresh, forbid twice
        // (stays exempt), unknown ids, the three silent kinds, and a sweep
        // that finds only an exempt entry left
        send_word(KIND_ADD, 16'h0000);
        send_word(KIND_ADD, 16'hFFFF);
        send_word(KIND_ADD, 16'h0000);
        send_word(KIND_FORBID, 16'hFFFF);
        send_word(KIND_FORBID, 16'hFFFF);
        send_word(KIND_DELETE, 16'hA5A5);
        send_word(KIND_FORBID, 16'h5A5A);
        send_word(kind_t'(5), 16'h1234);
        send_word(kind_t'(6), 16'hEDCB);
        send_word(kind_t'(7), 16'h0F0F);
        send_word(KIND_DELETE, 16'h0000);
        send_word(KIND_SWEEP, 16'h0000);
        send_word(KIND_TICK, 16'hFFFF);

        // Limit of zero rejects every add
        configure(1, 0);
        send_word(KIND_ADD, 16'h7E81);

        // Limit of two with one exempt entry held: fill, reject a new id and
        // a refresh while full, free a slot, then let both live entries expire
        configure(1, 2);
        send_word(KIND_ADD, 16'h0001);
        send_word(KIND_ADD, 16'h0002);
        send_word(KIND_ADD, 16'h0001);
        send_word(KIND_DELETE, 16'hFFFF);
        send_word(KIND_ADD, 16'h0002);
        send_word(KIND_TICK, 16'h0000);
        send_word(KIND_TICK, 16'h0000);
        send_word(KIND_SWEEP, 16'h0000);

        // Random part. Idling: sender light and sink heavy, then swapped,
        // then none at all.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            configure(PHASE_TIMEOUT[ph], PHASE_LIMIT[ph]);
            send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 71 : 0;
            recv_idle_pct <= (ph < 2) ? 71 : (ph < 4) ? 27 : 0;
            for (n = 0; n < ID_POOL; n++)
                pool[n] = id_t'($urandom());
            // Freeze the sink at the start of every phase while requests keep coming
            hold_requests <= hold_requests + 1;
            words = 0;
            while (words < PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    // Flood: overfill with fresh ids, age them past the
                    // deadline where the timeout is short, then sweep the lot
                    for (n = 0; n < DEPTH + 2; n++)
                    begin
                        send_word(KIND_ADD, id_t'($urandom()));
                        words++;
                    end
                    for (n = 0; n <= cur_timeout && n < 8; n++)
                    begin
                        send_word(KIND_TICK, id_t'($urandom()));
                        words++;
                    end
                    send_word(KIND_SWEEP, id_t'($urandom()));
                    words++;
                end
                else if (r < 88)
                begin
                    // Session traffic on a small pool of ids so that
                    // refreshes, deletes and forbids find their targets
                    if (r < 40)
                        send_word(KIND_ADD, pool[$urandom_range(0, ID_POOL - 1)]);
                    else if (r < 60)
                        send_word(KIND_TICK, id_t'($urandom()));
                    else if (r < 70)
                        send_word(KIND_SWEEP, id_t'($urandom()));
                    else if (r < 80)
                        send_word(KIND_DELETE, pool[$urandom_range(0, ID_POOL - 1)]);
                    else
                        send_word(KIND_FORBID, pool[$urandom_range(0, ID_POOL - 1)]);
                    words++;
                end
                else if (r < 92)
                    // Silent kinds: taken and dropped, not counted
                    send_word(kind_t'($urandom_range(5, 7)), id_t'($urandom()));
                else
                begin
                    // Noise: ids that are almost never in the table
                    if (r < 96)
                        send_word(KIND_DELETE, id_t'($urandom()));
                    else
                        send_word(KIND_FORBID, id_t'($urandom()));
                    words++;
                end
            end
        end

        // Hold off until every event word has come back, then decide
        settle();
        if (fail_count == 0 && pending_words == 0)
            $display("tb_idle_timeout_table passed");
        else
            $display("tb_idle_timeout_table failed");
        $finish;
    end

endmodule
